@@ rtl/core/pft_pkg.sv @@
// Package for the pausable frame timer: command codes, widths and constants.
package pft_pkg;

  localparam int CMD_W    = 4;
  localparam int AMOUNT_W = 16;
  localparam int RATE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int DIVISOR_W = 10;
  localparam int STEP_W   = 5;

  localparam logic [CMD_W-1:0] CMD_TICK     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_START_S  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_START_MS = 4'd2;
  localparam logic [CMD_W-1:0] CMD_START_F  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STOP     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RESTART  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PAUSE    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RESUME   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 4'd8;

  localparam logic [RATE_W-1:0]    RATE_RESET = 8'd50;
  localparam logic [DIVISOR_W-1:0] MS_PER_S   = 10'd1000;
  localparam logic [STEP_W-1:0]    LAST_STEP  = 5'd31;

  typedef logic [WORD_W-1:0] word_t;

endpackage

@@ rtl/core/pausable_frame_timer_top.sv @@
// Pausable frame timer: frame tick counter, one countdown timer and its status conversions.
// Each beat on the input carries one command; the block applies it and returns one status
// beat. The status conversions use a bit-serial restoring divider: four lanes share one
// divisor and retire one quotient bit each per cycle, producing elapsed and remaining time
// in milliseconds and seconds together. A start in milliseconds first runs the same lanes
// once to divide by 1000. A new command is taken while a finished status beat still waits
// on the output.
module pausable_frame_timer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pft_pkg::RATE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pft_pkg::CMD_W-1:0]     cmd,
  input  logic [pft_pkg::AMOUNT_W-1:0]  amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_active,
  output logic                          is_paused,
  output logic                          expired,
  output logic [pft_pkg::WORD_W-1:0]    elapsed_frames,
  output logic [pft_pkg::WORD_W-1:0]    elapsed_ms,
  output logic [pft_pkg::WORD_W-1:0]    elapsed_seconds,
  output logic [pft_pkg::WORD_W-1:0]    remaining_ms,
  output logic [pft_pkg::WORD_W-1:0]    remaining_seconds
);
  import pft_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_APPLY  = 4'd1;
  localparam logic [3:0] S_MSDIV  = 4'd2;
  localparam logic [3:0] S_BEGIN  = 4'd3;
  localparam logic [3:0] S_STATUS = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_LOAD   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state;
  logic [RATE_W-1:0]    refresh_rate;
  word_t                tick_count;
  word_t                start_frame;
  word_t                duration_frames;
  word_t                pause_frame;
  logic                 running;
  logic                 paused;

  logic [CMD_W-1:0]     cmd_q;
  logic [AMOUNT_W-1:0]  amount_q;
  word_t                el_q;
  word_t                rem_q;
  logic                 done_q;
  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W-1:0] div_by;

  word_t                lane_q [4];
  logic [DIVISOR_W-1:0] lane_r [4];
  word_t                lane_q_next [4];
  logic [DIVISOR_W-1:0] lane_r_next [4];
  logic [DIVISOR_W:0]   trial [4];
  logic                 fits [4];

  logic [23:0]          prod;
  word_t                now_frame;
  word_t                ms_dur;

  assign prod      = {8'd0, amount_q} * {16'd0, refresh_rate};
  assign now_frame = paused ? pause_frame : tick_count;
  assign ms_dur    = (lane_q[0] == '0) ? word_t'(1) : lane_q[0];
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i]       = {lane_r[i], lane_q[i][WORD_W-1]};
      fits[i]        = (trial[i] >= {1'b0, div_by});
      lane_r_next[i] = fits[i] ? DIVISOR_W'(trial[i] - {1'b0, div_by}) : trial[i][DIVISOR_W-1:0];
      lane_q_next[i] = {lane_q[i][WORD_W-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      refresh_rate    <= RATE_RESET;
      tick_count      <= '0;
      start_frame     <= '0;
      duration_frames <= '0;
      pause_frame     <= '0;
      running         <= 1'b0;
      paused          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        refresh_rate <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= cmd;
            amount_q <= amount;
            state    <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= (cmd_q == CMD_START_MS) ? S_MSDIV : S_STATUS;
          case (cmd_q)
            CMD_TICK: begin
              tick_count <= tick_count + word_t'(1);
            end
            CMD_START_S: begin
              start_frame     <= tick_count;
              duration_frames <= {8'd0, prod};
              running         <= 1'b1;
              paused          <= 1'b0;
            end
            CMD_START_MS: begin
              for (int i = 0; i < 4; i++) begin
                lane_q[i] <= {8'd0, prod};
                lane_r[i] <= '0;
              end
              div_by <= MS_PER_S;
              step   <= '0;
            end
            CMD_START_F: begin
              start_frame     <= tick_count;
              duration_frames <= {16'd0, amount_q};
              running         <= 1'b1;
              paused          <= 1'b0;
            end
            CMD_STOP: begin
              running <= 1'b0;
              paused  <= 1'b0;
            end
            CMD_RESTART: begin
              if (running) begin
                start_frame <= tick_count;
                paused      <= 1'b0;
              end
            end
            CMD_PAUSE: begin
              if (running && !paused) begin
                pause_frame <= tick_count;
                paused      <= 1'b1;
              end
            end
            CMD_RESUME: begin
              if (running && paused) begin
                start_frame <= start_frame + (tick_count - pause_frame);
                paused      <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_MSDIV: begin
          for (int i = 0; i < 4; i++) begin
            lane_q[i] <= lane_q_next[i];
            lane_r[i] <= lane_r_next[i];
          end
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= S_BEGIN;
          end
        end
        S_BEGIN: begin
          start_frame     <= tick_count;
          duration_frames <= ms_dur;
          running         <= 1'b1;
          paused          <= 1'b0;
          state           <= S_STATUS;
        end
        S_STATUS: begin
          el_q  <= running ? (now_frame - start_frame) : '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          done_q <= (el_q >= duration_frames);
          rem_q  <= duration_frames - el_q;
          state  <= S_LOAD;
        end
        S_LOAD: begin
          lane_q[0] <= el_q * word_t'(MS_PER_S);
          lane_q[1] <= el_q;
          lane_q[2] <= rem_q * word_t'(MS_PER_S);
          lane_q[3] <= rem_q;
          for (int i = 0; i < 4; i++) begin
            lane_r[i] <= '0;
          end
          div_by <= {2'd0, refresh_rate};
          step   <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 4; i++) begin
            lane_q[i] <= lane_q_next[i];
            lane_r[i] <= lane_r_next[i];
          end
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            is_active         <= running;
            is_paused         <= paused;
            expired           <= running && !paused && done_q;
            elapsed_frames    <= el_q;
            elapsed_ms        <= running ? lane_q[0] : '0;
            elapsed_seconds   <= running ? lane_q[1] : '0;
            remaining_ms      <= (running && !done_q) ? lane_q[2] : '0;
            remaining_seconds <= (running && !done_q) ? lane_q[3] : '0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/pausable_frame_timer_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pausable frame timer, comparing every status beat with a prediction.
module pausable_frame_timer_top_tb;
  import pft_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_CMDS   = 50;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_SHOWN    = 10;
  localparam int NUM_RATES    = 6;

  typedef struct {
    logic [CMD_W-1:0]    code;
    logic [AMOUNT_W-1:0] amt;
  } timer_cmd_t;

  typedef struct {
    logic  active;
    logic  paused;
    logic  expired;
    word_t el_frames;
    word_t el_ms;
    word_t el_s;
    word_t rem_ms;
    word_t rem_s;
  } timer_status_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_e;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [RATE_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = '0;
  logic [AMOUNT_W-1:0] amount = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                is_active;
  logic                is_paused;
  logic                expired;
  word_t               elapsed_frames;
  word_t               elapsed_ms;
  word_t               elapsed_seconds;
  word_t               remaining_ms;
  word_t               remaining_seconds;

  timer_cmd_t    pending_cmds[$];
  timer_status_t expected_status[$];

  logic [RATE_W-1:0] frame_rate = RATE_RESET;
  word_t             frame_ticks = '0;
  word_t             timer_origin = '0;
  word_t             timer_length = '0;
  word_t             pause_mark = '0;
  logic              timer_on = 1'b0;
  logic              timer_held = 1'b0;

  logic     in_beat = 1'b0;
  int       fails = 0;
  int       beats_out = 0;
  int       cmds_loaded = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  int       seg_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       quiet = 0;

  pausable_frame_timer_top u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .amount            (amount),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .is_active         (is_active),
    .is_paused         (is_paused),
    .expired           (expired),
    .elapsed_frames    (elapsed_frames),
    .elapsed_ms        (elapsed_ms),
    .elapsed_seconds   (elapsed_seconds),
    .remaining_ms      (remaining_ms),
    .remaining_seconds (remaining_seconds)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  function automatic word_t per_rate(input word_t v);
    if (frame_rate == '0) return '1;
    return v / word_t'(frame_rate);
  endfunction

  function automatic void arm_timer(input word_t length);
    timer_origin = frame_ticks;
    timer_length = length;
    timer_on     = 1'b1;
    timer_held   = 1'b0;
  endfunction

  function automatic timer_status_t status_after(input logic [CMD_W-1:0] c,
                                                 input logic [AMOUNT_W-1:0] amt);
    timer_status_t s;
    word_t         now;
    word_t         el;
    word_t         rem;
    word_t         length;
    word_t         el_scaled;
    word_t         rem_scaled;
    logic          done;
    el   = '0;
    rem  = '0;
    done = 1'b0;
    case (c)
      CMD_TICK: begin
        frame_ticks = frame_ticks + 1;
      end
      CMD_START_S: begin
        arm_timer(word_t'(amt) * word_t'(frame_rate));
      end
      CMD_START_MS: begin
        length = (word_t'(amt) * word_t'(frame_rate)) / word_t'(MS_PER_S);
        arm_timer((length == '0) ? word_t'(1) : length);
      end
      CMD_START_F: begin
        arm_timer(word_t'(amt));
      end
      CMD_STOP: begin
        timer_on   = 1'b0;
        timer_held = 1'b0;
      end
      CMD_RESTART: begin
        if (timer_on) begin
          timer_origin = frame_ticks;
          timer_held   = 1'b0;
        end
      end
      CMD_PAUSE: begin
        if (timer_on && !timer_held) begin
          pause_mark = frame_ticks;
          timer_held = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (timer_on && timer_held) begin
          timer_origin = timer_origin + (frame_ticks - pause_mark);
          timer_held   = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (timer_on) begin
      now  = timer_held ? pause_mark : frame_ticks;
      el   = now - timer_origin;
      done = (el >= timer_length);
      if (!done) rem = timer_length - el;
    end
    el_scaled   = el * word_t'(MS_PER_S);
    rem_scaled  = rem * word_t'(MS_PER_S);
    s.active    = timer_on;
    s.paused    = timer_held;
    s.expired   = timer_on && !timer_held && done;
    s.el_frames = el;
    s.el_ms     = timer_on ? per_rate(el_scaled) : '0;
    s.el_s      = timer_on ? per_rate(el) : '0;
    s.rem_ms    = (timer_on && !done) ? per_rate(rem_scaled) : '0;
    s.rem_s     = (timer_on && !done) ? per_rate(rem) : '0;
    return s;
  endfunction

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      fails++;
      if (fails <= MAX_SHOWN) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    timer_status_t want;
    in_beat <= in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (expected_status.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN) begin
          $display("%0t: status beat with no command outstanding", $time);
        end
      end else begin
        want = expected_status.pop_front();
        check_field("is_active", word_t'(want.active), word_t'(is_active));
        check_field("is_paused", word_t'(want.paused), word_t'(is_paused));
        check_field("expired", word_t'(want.expired), word_t'(expired));
        check_field("elapsed_frames", want.el_frames, elapsed_frames);
        check_field("elapsed_ms", want.el_ms, elapsed_ms);
        check_field("elapsed_seconds", want.el_s, elapsed_seconds);
        check_field("remaining_ms", want.rem_ms, remaining_ms);
        check_field("remaining_seconds", want.rem_s, remaining_seconds);
      end
    end
    if (!rst && in_valid && in_ready) begin
      expected_status.push_back(status_after(cmd, amount));
    end
  end

  always @(negedge clk) begin : sender
    logic       offer;
    timer_cmd_t next_cmd;
    offer = in_valid && !in_beat;
    if (!offer && !rst) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        offer = 1'b1;
        cmd <= next_cmd.code;
        amount <= next_cmd.amt;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= offer;
  end

  always @(negedge clk) begin : receiver
    logic take;
    if (hold_left != 0) begin
      hold_left--;
      take = 1'b0;
    end else if (!hold_done && beats_out >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      take = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        rx_mode = rx_mode_e'($urandom_range(0, 2));
      end
      seg_left--;
      case (rx_mode)
        RX_FREE: take = 1'b1;
        RX_COIN: take = ($urandom_range(0, 1) == 1);
        default: take = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready <= take;
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [AMOUNT_W-1:0] amt);
    timer_cmd_t t;
    t.code = c;
    t.amt = amt;
    pending_cmds.push_back(t);
    cmds_loaded++;
  endtask

  function automatic logic [AMOUNT_W-1:0] pick_amount(input int hi);
    if ($urandom_range(0, 7) == 0) return AMOUNT_W'($urandom_range(0, 2**AMOUNT_W - 1));
    return AMOUNT_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [AMOUNT_W-1:0] any_amount();
    return AMOUNT_W'($urandom_range(0, 2**AMOUNT_W - 1));
  endfunction

  task automatic add_timer_run();
    int steps;
    int roll;
    case ($urandom_range(0, 2))
      0: push_cmd(CMD_START_S, pick_amount(2));
      1: push_cmd(CMD_START_MS, pick_amount(300));
      default: push_cmd(CMD_START_F, pick_amount(20));
    endcase
    steps = $urandom_range(4, 30);
    repeat (steps) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) push_cmd(CMD_TICK, any_amount());
      else if (roll < 70) push_cmd(CMD_PAUSE, any_amount());
      else if (roll < 80) push_cmd(CMD_RESUME, any_amount());
      else if (roll < 87) push_cmd(CMD_QUERY, any_amount());
      else if (roll < 93) push_cmd(CMD_RESTART, any_amount());
      else push_cmd(CMD_W'($urandom_range(CMD_QUERY + 1, 2**CMD_W - 1)), any_amount());
    end
    if ($urandom_range(0, 3) == 0) push_cmd(CMD_STOP, any_amount());
  endtask

  task automatic load_random(input int n);
    int target;
    target = cmds_loaded + n;
    while (cmds_loaded < target) begin
      if ($urandom_range(0, 9) < 7) begin
        add_timer_run();
      end else begin
        push_cmd(CMD_W'($urandom_range(0, 2**CMD_W - 1)), any_amount());
      end
    end
  endtask

  task automatic load_directed();
    push_cmd(CMD_QUERY, '0);
    push_cmd(CMD_PAUSE, '0);
    push_cmd(CMD_RESUME, '0);
    push_cmd(CMD_RESTART, '1);
    push_cmd(CMD_START_F, '0);
    push_cmd(CMD_TICK, '1);
    push_cmd(CMD_START_MS, 16'd1);
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_START_S, '1);
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_PAUSE, '0);
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_PAUSE, '0);
    push_cmd(CMD_RESUME, '1);
    push_cmd(CMD_RESTART, '0);
    push_cmd(CMD_START_MS, '1);
    push_cmd(CMD_START_F, '1);
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_STOP, '0);
    push_cmd(CMD_RESUME, '0);
    push_cmd(CMD_W'(2**CMD_W - 1), '1);
    push_cmd(CMD_W'(CMD_QUERY + 1), '0);
    push_cmd(CMD_START_F, 16'd3);
    push_cmd(CMD_QUERY, '0);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] r);
    @(negedge clk);
    cfg_wdata <= r;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_rate = r;
  endtask

  initial begin : stimulus
    logic [RATE_W-1:0] rates [NUM_RATES];
    int                k;
    rates[0] = '1;
    rates[1] = RATE_W'(1);
    rates[2] = '0;
    rates[3] = RATE_W'(60);
    rates[4] = RATE_W'($urandom_range(2, 254));
    rates[5] = RATE_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    load_directed();
    load_random(PHASE_CMDS);
    for (k = 0; k < NUM_RATES; k++) begin
      wait_drained();
      write_rate(rates[k]);
      load_random(PHASE_CMDS);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
